FILE: design/smbp_pkg.sv
`default_nettype none

package smbp_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CODE_W      = 8;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 10;
    localparam int DIM_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int M_TDATA_W   = 32;
    localparam int MAX_HEIGHT  = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    typedef logic [PIXEL_W-1:0] pixel_t;

endpackage

`default_nettype wire

FILE: design/sobel_mean_binary_pattern_3x3_unit.sv
// Streaming 3x3 Sobel mean binary pattern. Pixels enter in raster order at one per clock
// and each interior centre yields one code; m_tvalid rises once the pixel that completes its
// window has passed the line-store read, window and sum stages into the output register, and
// border positions produce no transfer. The two previous rows live in a single dual-port RAM
// of MAX_WIDTH words that holds both rows side by side: a pixel reads its column when it is
// accepted, and the same column is written back with the rows moved up as the pixel leaves the
// line-store read stage, so the sustained rate is one pixel per clock, limited only by output
// backpressure. Writing either dimension register restarts the frame at row 0, column 0; write
// them only while the block is idle. Widths above MAX_WIDTH and heights above 1024 are used saturated.
`default_nettype none

module sobel_mean_binary_pattern_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [smbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [smbp_pkg::DIM_W-1:0]          cfg_data,
    // Pixel input.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [smbp_pkg::PIXEL_W-1:0]        s_tdata,   // [7:0] pixel
    // Code output.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [smbp_pkg::M_TDATA_W-1:0]           m_tdata,   // [7:0] code, [17:8] out_row,
                                                                // [27:18] out_col, [31:28] zero
    output logic                                     m_tlast    // last_of_frame
);

    import smbp_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WB > DIM_W) ? WB : DIM_W;

    // Configuration and effective dimensions.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [CW-1:0]    width_ext;
    logic [CW-1:0]    width_use;
    logic [CW-1:0]    width_m1;
    logic [DIM_W-1:0] height_use;
    logic [DIM_W-1:0] height_m1;
    logic [CB-1:0]    col_last;
    logic [ROW_W-1:0] row_last;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        width_ext = CW'(width_reg);
        if (width_ext < CW'(3))
            width_use = CW'(3);
        else if (width_ext > CW'(MAX_WIDTH))
            width_use = CW'(MAX_WIDTH);
        else
            width_use = width_ext;
        width_m1 = width_use - CW'(1);
        col_last = width_m1[CB-1:0];

        if (height_reg < DIM_W'(3))
            height_use = DIM_W'(3);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            height_use = DIM_W'(MAX_HEIGHT);
        else
            height_use = height_reg;
        height_m1 = height_use - DIM_W'(1);
        row_last  = height_m1[ROW_W-1:0];
    end

    // Pipeline control: every stage moves together when the output register can take data.
    logic advance;
    logic accept;
    logic out_valid_reg;

    assign advance  = ~out_valid_reg | m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid & advance;

    // Frame position of the next pixel.
    logic [CB-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == col_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == row_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CB'(1);
            end
        end
    end

    // Stage 1: line store read in flight.
    logic             valid1_reg;
    pixel_t           px1_reg;
    logic [CB-1:0]    col1_reg;
    logic             emit1_reg;
    logic             last1_reg;
    logic [ROW_W-1:0] orow1_reg;
    logic [COL_W-1:0] ocol1_reg;
    logic [CB-1:0]    col_m2;

    assign col_m2 = col_reg - CB'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px1_reg   <= s_tdata;
            col1_reg  <= col_reg;
            emit1_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= CB'(2));
            last1_reg <= (row_reg == row_last) && (col_reg == col_last);
            orow1_reg <= row_reg - ROW_W'(2);
            ocol1_reg <= COL_W'(col_m2);
        end
    end

    // Both rows in one word: upper byte is the previous row, lower byte the row before.
    // A column is read when a pixel is accepted and written back when that pixel leaves stage 1;
    // consecutive pixels never share a column since a row has at least three pixels, so no forwarding is needed.
    logic [2*PIXEL_W-1:0] rd_data;
    logic                 wr_en;
    pixel_t               top_px;
    pixel_t               mid_px;

    assign wr_en  = valid1_reg & advance;
    assign mid_px = rd_data[2*PIXEL_W-1:PIXEL_W];
    assign top_px = rd_data[PIXEL_W-1:0];

    smbp_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (col1_reg),
        .wr_data ({px1_reg, mid_px}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    // Stage 2: 3x3 window.
    pixel_t           window_reg [3][3];
    logic             valid2_reg;
    logic             last2_reg;
    logic [ROW_W-1:0] orow2_reg;
    logic [COL_W-1:0] ocol2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    window_reg[i][j] <= '0;
                end
            end
        end
        else if (advance)
        begin
            valid2_reg <= valid1_reg & emit1_reg;
            if (valid1_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    window_reg[i][0] <= window_reg[i][1];
                    window_reg[i][1] <= window_reg[i][2];
                end
                window_reg[0][2] <= top_px;
                window_reg[1][2] <= mid_px;
                window_reg[2][2] <= px1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid1_reg)
        begin
            last2_reg <= last1_reg;
            orow2_reg <= orow1_reg;
            ocol2_reg <= ocol1_reg;
        end
    end

    // Stage 3: directional sums (mod 256) and neighbour mean.
    pixel_t           nb [8];
    pixel_t           dir_sum [8];
    logic [DIM_W-1:0] total;

    always_comb
    begin
        nb[0] = window_reg[0][0];
        nb[1] = window_reg[0][1];
        nb[2] = window_reg[0][2];
        nb[3] = window_reg[1][2];
        nb[4] = window_reg[2][2];
        nb[5] = window_reg[2][1];
        nb[6] = window_reg[2][0];
        nb[7] = window_reg[1][0];
        total = '0;
        for (int k = 0; k < 8; k++)
        begin
            total = total + DIM_W'(nb[k]);
        end
        // Sum k is centred on neighbour (1 - k) mod 8; all terms wrap at eight bits.
        for (int k = 0; k < 8; k++)
        begin
            dir_sum[k] = nb[(9 - k + 7) % 8] + (nb[(9 - k) % 8] << 1) + nb[(9 - k + 1) % 8]
                       - nb[(9 - k + 3) % 8] - (nb[(9 - k + 4) % 8] << 1)
                       - nb[(9 - k + 5) % 8];
        end
    end

    pixel_t           sum3_reg [8];
    pixel_t           mean3_reg;
    logic             valid3_reg;
    logic             last3_reg;
    logic [ROW_W-1:0] orow3_reg;
    logic [COL_W-1:0] ocol3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid2_reg)
        begin
            sum3_reg  <= dir_sum;
            mean3_reg <= total[DIM_W-1:3];
            last3_reg <= last2_reg;
            orow3_reg <= orow2_reg;
            ocol3_reg <= ocol2_reg;
        end
    end

    // Output register: threshold each sum against the mean.
    logic [CODE_W-1:0] code_next;
    logic [CODE_W-1:0] code_reg;
    logic              last_reg;
    logic [ROW_W-1:0]  orow_reg;
    logic [COL_W-1:0]  ocol_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            code_next[7 - k] = (sum3_reg[k] >= mean3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid3_reg)
        begin
            code_reg <= code_next;
            last_reg <= last3_reg;
            orow_reg <= orow3_reg;
            ocol_reg <= ocol3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W - CODE_W - ROW_W - COL_W)'(0), ocol_reg, orow_reg, code_reg};

endmodule

`default_nettype wire

FILE: design/smbp_ram.sv
`default_nettype none

module smbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/smbp_checker.sv
`default_nettype none

module smbp_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                cfg_valid,
    input wire logic                                cfg_ready,
    input wire logic [smbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input wire logic [smbp_pkg::DIM_W-1:0]          cfg_data,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic [smbp_pkg::PIXEL_W-1:0]        s_tdata,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [smbp_pkg::M_TDATA_W-1:0]      m_tdata,
    input wire logic                                m_tlast
);

    import smbp_pkg::*;

    // A stalled result transfer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // With no result waiting, the block must take pixels.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // Result rows never exceed 1021, the highest window top row of the largest frame.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[17:8] <= 10'd1021)
        else $error("result row out of range");

    // Padding bits of the result word are zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:28] == 4'd0)
        else $error("result padding not zero");

endmodule

bind sobel_mean_binary_pattern_3x3_unit smbp_checker u_smbp_checker (.*);

`default_nettype wire
